/* src/md5_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, constants and round tables for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic       end_of_message;
        logic       byte_valid;
        logic [7:0] data_byte;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } md5_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } md5_state_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word index used by round r.
    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] w;
        unique case (r[5:4])
            2'd0:    w = r[3:0];
            2'd1:    w = 4'(({r[3:0], 2'b00} + r[3:0]) + 4'd1);
            2'd2:    w = 4'(({r[3:0], 1'b0} + r[3:0]) + 4'd5);
            default: w = 4'(({r[3:0], 3'b000}) - r[3:0]);
        endcase
        return w;
    endfunction

endpackage

/* src/md5_block_ram.sv */
// ----------------------------------------------------------------------------
// MD5 message block memory
// Sixteen 32-bit words with byte write enables and a registered read port.
// ----------------------------------------------------------------------------
module md5_block_ram (
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [3:0]  wr_addr,
    input  logic [3:0]  wr_be,
    input  logic [31:0] wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [16];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < 4; i++) begin
                if (wr_be[i]) begin
                    mem[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
                end
            end
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/md5_message_digest.sv */
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 with padding, length append and one digest per message.
// ----------------------------------------------------------------------------
// Each request carries at most one byte, and the byte goes straight into a
// 16-word block memory. While idle the block takes one request per cycle.
// The request that completes a 64-byte block is followed by a compression
// with s_ready low: a first memory read, 64 rounds at one per cycle (one
// memory read per round) and the chaining update. An end-of-message request
// starts the padding. Padding bytes are written one per cycle from the
// current position to the end of the block, and each padded block is
// followed by a compression. When fewer than 8 bytes are left for the
// length, a second padded block of 64 bytes and a second compression follow.
// The digest is then held on m_data until it is taken, and s_ready returns
// in the cycle after that.
module md5_message_digest (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md5_pkg::md5_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output md5_pkg::md5_out_t m_data
);

    md5_pkg::md5_state_t state_reg, state_next;
    logic [31:0] cv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] bit_count_reg, total_reg;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  round_reg;
    logic        fetch_reg;          // first memory read of a block is in flight
    logic        closing_reg;        // padded tail of a message is in progress
    logic        first_reg;          // next padding byte is the 0x80 marker
    logic        len_blk_reg;        // this padded block carries the bit length
    logic        pending_end_reg;    // end arrived with the byte that filled a block
    md5_pkg::md5_out_t out_reg;

    logic        wr_en;
    logic [3:0]  wr_addr, wr_be;
    logic [31:0] wr_data, rd_data;
    logic [3:0]  rd_addr;
    logic [7:0]  pad_byte;
    logic [31:0] f_val, t_sum, t_rot;
    logic        acc;

    md5_block_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_be   (wr_be),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign acc = s_valid && s_ready;
    assign m_valid = (state_reg == md5_pkg::ST_OUT);
    assign m_data = out_reg;

    // Address of the word read now: that of the next round (round 0 during the first read), for the registered read.
    always_comb begin
        if (state_reg == md5_pkg::ST_ROUND && !fetch_reg) begin
            rd_addr = md5_pkg::word_index(6'(round_reg + 6'd1));
        end else begin
            rd_addr = md5_pkg::word_index(6'd0);
        end
    end

    // Padding byte at pos_reg: 0x80 first, zeros, then the bit length.
    always_comb begin
        if (first_reg) begin
            pad_byte = 8'h80;
        end else if (len_blk_reg && pos_reg >= 6'd56) begin
            pad_byte = total_reg[{pos_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        unique case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_sum = a_reg + f_val + rd_data + md5_pkg::round_const(round_reg);
        t_rot = (t_sum << md5_pkg::rot_amount(round_reg))
              | (t_sum >> (6'd32 - {1'b0, md5_pkg::rot_amount(round_reg)}));
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg[5:2];
        wr_be      = 4'b0001 << pos_reg[1:0];
        wr_data    = {4{s_data.data_byte}};
        pos_next   = pos_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_data.byte_valid) begin
                    wr_en    = 1'b1;
                    pos_next = 6'(pos_reg + 6'd1);
                end
                if (s_valid) begin
                    priority if (s_data.byte_valid && pos_reg == 6'd63) begin
                        state_next = md5_pkg::ST_ROUND;
                    end else if (s_data.end_of_message) begin
                        state_next = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_PAD: begin
                wr_en    = 1'b1;
                wr_data  = {4{pad_byte}};
                pos_next = 6'(pos_reg + 6'd1);
                if (pos_reg == 6'd63) begin
                    state_next = md5_pkg::ST_ROUND;
                end
            end
            md5_pkg::ST_ROUND: begin
                if (!fetch_reg && round_reg == 6'd63) begin
                    state_next = md5_pkg::ST_FINAL;
                end
            end
            md5_pkg::ST_FINAL: begin
                priority if (closing_reg && len_blk_reg) begin
                    state_next = md5_pkg::ST_OUT;
                end else if (closing_reg || pending_end_reg) begin
                    state_next = md5_pkg::ST_PAD;
                end else begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            md5_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default: state_next = md5_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= md5_pkg::ST_IDLE;
            cv_reg[0]       <= md5_pkg::IV0;
            cv_reg[1]       <= md5_pkg::IV1;
            cv_reg[2]       <= md5_pkg::IV2;
            cv_reg[3]       <= md5_pkg::IV3;
            bit_count_reg   <= '0;
            pos_reg         <= '0;
            round_reg       <= '0;
            fetch_reg       <= 1'b0;
            closing_reg     <= 1'b0;
            first_reg       <= 1'b0;
            len_blk_reg     <= 1'b0;
            pending_end_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            unique case (state_reg)
                md5_pkg::ST_IDLE: begin
                    if (acc && s_data.byte_valid) begin
                        bit_count_reg <= bit_count_reg + 64'd8;
                    end
                    if (acc && s_data.byte_valid && pos_reg == 6'd63) begin
                        fetch_reg       <= 1'b1;
                        round_reg       <= '0;
                        pending_end_reg <= s_data.end_of_message;
                    end
                    if (acc && s_data.end_of_message && !(s_data.byte_valid
                            && pos_reg == 6'd63)) begin
                        total_reg   <= bit_count_reg
                                     + (s_data.byte_valid ? 64'd8 : 64'd0);
                        closing_reg <= 1'b1;
                        first_reg   <= 1'b1;
                        // The length fits behind the marker only below byte 56.
                        len_blk_reg <= (pos_next < 6'd56);
                    end
                end
                md5_pkg::ST_PAD: begin
                    first_reg <= 1'b0;
                    if (pos_reg == 6'd63) begin
                        fetch_reg <= 1'b1;
                        round_reg <= '0;
                    end
                end
                md5_pkg::ST_ROUND: begin
                    if (fetch_reg) begin
                        fetch_reg <= 1'b0;
                        a_reg <= cv_reg[0];
                        b_reg <= cv_reg[1];
                        c_reg <= cv_reg[2];
                        d_reg <= cv_reg[3];
                    end else begin
                        a_reg     <= d_reg;
                        d_reg     <= c_reg;
                        c_reg     <= b_reg;
                        b_reg     <= t_rot + b_reg;
                        round_reg <= 6'(round_reg + 6'd1);
                    end
                end
                md5_pkg::ST_FINAL: begin
                    if (closing_reg && len_blk_reg) begin
                        out_reg.digest_low  <= {cv_reg[1] + b_reg, cv_reg[0] + a_reg};
                        out_reg.digest_high <= {cv_reg[3] + d_reg, cv_reg[2] + c_reg};
                        cv_reg[0]     <= md5_pkg::IV0;
                        cv_reg[1]     <= md5_pkg::IV1;
                        cv_reg[2]     <= md5_pkg::IV2;
                        cv_reg[3]     <= md5_pkg::IV3;
                        bit_count_reg <= '0;
                        closing_reg   <= 1'b0;
                        len_blk_reg   <= 1'b0;
                    end else begin
                        cv_reg[0] <= cv_reg[0] + a_reg;
                        cv_reg[1] <= cv_reg[1] + b_reg;
                        cv_reg[2] <= cv_reg[2] + c_reg;
                        cv_reg[3] <= cv_reg[3] + d_reg;
                        if (closing_reg) begin
                            len_blk_reg <= 1'b1;
                        end else if (pending_end_reg) begin
                            total_reg       <= bit_count_reg;
                            closing_reg     <= 1'b1;
                            first_reg       <= 1'b1;
                            len_blk_reg     <= 1'b1;
                            pending_end_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The digest holds steady while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data));

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid));

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != md5_pkg::ST_ROUND |-> round_reg == 6'd0);

    assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_reg |-> state_reg == md5_pkg::ST_ROUND);

endmodule

/* tb/sv/md5_message_digest_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams messages of random length and content through the block, computes
// each expected digest locally and checks every digest that comes out.
// ----------------------------------------------------------------------------
module md5_message_digest_tb;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    md5_pkg::md5_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    md5_pkg::md5_out_t m_data;

    md5_message_digest u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
        32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
        32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
        32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
        32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
        32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int S_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Local digest state.
    logic [31:0] hash_word [4];
    logic [31:0] blk_word [16];
    logic [63:0] msg_bits;

    md5_pkg::md5_in_t  pending_req [$];
    md5_pkg::md5_out_t digest_q [$];
    int n_err = 0;
    int n_digests = 0;
    int n_bytes = 0;
    int n_sent = 0;
    bit calm;
    bit hold_long;

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] a, b, c, d, f, t;
        int w;
        a = hash_word[0]; b = hash_word[1]; c = hash_word[2]; d = hash_word[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); w = r; end
                1: begin f = (b & d) | (c & ~d); w = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; w = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); w = (7 * r) % 16; end
            endcase
            t = rol(a + f + blk_word[w] + K_TAB[r], S_TAB[(r / 16) * 4 + r % 4]) + b;
            a = d; d = c; c = b; b = t;
        end
        hash_word[0] += a; hash_word[1] += b; hash_word[2] += c; hash_word[3] += d;
    endtask

    task automatic put_byte(int pos, logic [7:0] v);
        blk_word[pos / 4][(pos % 4) * 8 +: 8] = v;
    endtask

    task automatic restart_digest();
        hash_word[0] = md5_pkg::IV0; hash_word[1] = md5_pkg::IV1;
        hash_word[2] = md5_pkg::IV2; hash_word[3] = md5_pkg::IV3;
        msg_bits = '0;
    endtask

    task automatic absorb_request(md5_pkg::md5_in_t req);
        int pos;
        logic [63:0] total;
        md5_pkg::md5_out_t res;
        if (req.byte_valid) begin
            pos = int'(msg_bits[8:3]);
            put_byte(pos, req.data_byte);
            msg_bits += 64'd8;
            if (pos == 63) compress();
        end
        if (req.end_of_message) begin
            total = msg_bits;
            pos = int'(msg_bits[8:3]);
            put_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin put_byte(pos, 8'h00); pos++; end
                compress();
                pos = 0;
            end
            while (pos < 56) begin put_byte(pos, 8'h00); pos++; end
            blk_word[14] = total[31:0];
            blk_word[15] = total[63:32];
            compress();
            res.digest_low  = {hash_word[1], hash_word[0]};
            res.digest_high = {hash_word[3], hash_word[2]};
            digest_q.push_back(res);
            restart_digest();
        end
    endtask

    task automatic add_message(int len, int mode);
        md5_pkg::md5_in_t req;
        for (int i = 0; i < len; i++) begin
            req.data_byte = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
            req.byte_valid = 1'b1;
            req.end_of_message = 1'b0;
            // Occasionally close on the last byte itself.
            if (i == len - 1 && $urandom_range(1, 0) == 1) req.end_of_message = 1'b1;
            pending_req.push_back(req);
            // Sprinkle ignored items inside the message.
            if ($urandom_range(19, 0) == 0) begin
                req = '{end_of_message: 1'b0, byte_valid: 1'b0, data_byte: 8'($urandom)};
                pending_req.push_back(req);
            end
        end
        if (len == 0 || !pending_req[$].end_of_message) begin
            req = '{end_of_message: 1'b1, byte_valid: 1'b0, data_byte: 8'($urandom)};
            pending_req.push_back(req);
        end
    endtask

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Driver: accepted requests feed the local digest model.
    int gap_cnt;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_request(s_data);
                n_sent++;
                if (s_data.byte_valid) n_bytes++;
            end
            if (!s_valid || s_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt <= gap_cnt - 1;
                    s_valid <= 1'b0;
                end else if (pending_req.size() > 0) begin
                    s_data  <= pending_req.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(7, 0) == 0) gap_cnt <= $urandom_range(15, 1);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stalls.
    int stall_cnt;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("ERROR: unexpected digest %h", m_data);
                end else begin
                    md5_pkg::md5_out_t exp_d;
                    exp_d = digest_q.pop_front();
                    if (m_data.digest_low !== exp_d.digest_low
                        || m_data.digest_high !== exp_d.digest_high) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("ERROR: digest %0d expected %h_%h got %h_%h", n_digests,
                                     exp_d.digest_high, exp_d.digest_low,
                                     m_data.digest_high, m_data.digest_low);
                    end
                end
                n_digests++;
            end
            if (hold_long) begin
                m_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(7, 0) == 0) begin
                stall_cnt <= $urandom_range(15, 1);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering short messages.
    initial begin
        hold_long = 1'b0;
        wait (n_digests >= 12);
        hold_long = 1'b1;
        repeat (3000) @(posedge aclk);
        hold_long = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("md5_message_digest test failed");
        $finish;
    end

    initial begin
        calm = 1'b0;
        aclk = 1'b0;
        restart_digest();
        for (int i = 0; i < 16; i++) blk_word[i] = '0;
        aresetn = 1'b0;

        // Directed: empty message, ignored item, padding boundaries, extremes.
        pending_req.push_back('{end_of_message: 1'b0, byte_valid: 1'b0, data_byte: 8'hff});
        add_message(0, 0);
        add_message(1, 1);
        add_message(3, 2);
        add_message(1, 0);
        add_message(0, 0);
        // 55 bytes still fit one padded block; 56 and 64 bytes need one more.
        add_message(55, 0);
        add_message(56, 1);
        add_message(64, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Random: mostly short messages, a few long ones; tail runs without gaps.
        while (pending_req.size() + n_sent < 950) begin
            if ($urandom_range(9, 0) == 0) add_message($urandom_range(130, 57), 0);
            else add_message($urandom_range(20, 0), 0);
            if (pending_req.size() + n_sent > 800) calm = 1'b1;
            while (pending_req.size() > 40) @(posedge aclk);
        end
        wait (pending_req.size() == 0 && !s_valid);
        while (digest_q.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d requests holding %0d message bytes; checked %0d digests.",
                 n_sent, n_bytes, n_digests);
        if (n_err == 0 && digest_q.size() == 0) begin
            $display("md5_message_digest test passed");
        end else begin
            $display("Mismatches: %0d", n_err);
            $display("md5_message_digest test failed");
        end
        $finish;
    end

endmodule
